// ===== src/dfs_pkg.sv =====
// Shared types and constants of the delimited field splitter.
// Holds the result item layout, the register indexes and the reset values.
// No dependencies.
package dfs_pkg;

  // Largest delimiter the block can hold, and so the size of the held window.
  localparam int DELIM_MAX_DEF = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE       = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [2:0]  DELIM_LEN_RST   = 3'd1;
  localparam logic [31:0] DELIM_BYTES_RST = 32'd44;
  localparam logic [7:0]  QUOTE_RST       = 8'd34;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       stream_end;
    logic       quote_error;
  } result_t;

endpackage

// ===== src/delimited_field_splitter_core.sv =====
// Top level of the delimited field splitter: configuration registers,
// input register, scan logic and result queue.
// Depends on dfs_pkg, dfs_resolver and dfs_result_queue.
//
// Usage. The input channel carries one item per handshake: a data byte
// (in_kind low) or the end of a stream (in_kind high). The result channel
// carries one item per handshake: either one content byte or one field end.
// The end item of a stream always gives a final field end with
// out_stream_end set, and out_quote_error set if a quoted span was left
// open; downstream should then discard that stream's output.
// An accepted item is held in the input register, resolved from there as
// its results are written into the queue, and shown from the queue head.
// Throughput: one input item per cycle. An item gives up to DELIM_MAX
// results, which leave one per cycle from a queue of 2*DELIM_MAX entries;
// input is stalled while the queue has fewer than DELIM_MAX free entries,
// so the output port sets the sustained rate when bytes are released in
// bursts after a partial delimiter match.
// When the receiver stalls, the head result holds and the queue fills;
// input keeps flowing until the queue is nearly full.
// Reset (synchronous, active low) empties the queue and input register,
// clears the held window and quote state, and sets the delimiter to a
// single comma and the quote byte to a double quote.
module delimited_field_splitter_core
  import dfs_pkg::*;
#(
  parameter int DELIM_MAX = DELIM_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [7:0]           in_byte,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic                 out_field_end,
  output logic                 out_stream_end,
  output logic                 out_quote_error
);

  localparam int CW = $clog2(DELIM_MAX+1);

  // Configuration registers.
  logic [2:0]  dlen_r;
  logic [31:0] delim_r;
  logic [7:0]  quote_r;

  // Input register.
  logic       in_vld_r;
  logic       in_kind_r;
  logic [7:0] in_byte_r;

  logic          room;
  logic          go;
  result_t       res  [DELIM_MAX];
  logic [CW-1:0] res_n;
  logic [CW-1:0] wr_n;
  result_t       head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r  <= DELIM_LEN_RST;
      delim_r <= DELIM_BYTES_RST;
      quote_r <= QUOTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELIM_LEN:   dlen_r  <= cfg_data[2:0];
        CFG_DELIM_BYTES: delim_r <= cfg_data;
        CFG_QUOTE:       quote_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The registered item moves on once the queue can take its worst case
  // of DELIM_MAX results; the register reloads in that same cycle.
  assign go       = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign wr_n     = go ? res_n : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_kind_r <= in_kind;
      in_byte_r <= in_byte;
    end
  end

  dfs_resolver #(
    .N (DELIM_MAX)
  ) u_resolver (
    .clk        (clk),
    .rst_n      (rst_n),
    .go_i       (go),
    .final_i    (in_kind_r),
    .byte_i     (in_byte_r),
    .dlen_cfg_i (dlen_r),
    .delim_i    (delim_r),
    .quote_i    (quote_r),
    .res_o      (res),
    .res_n_o    (res_n)
  );

  dfs_result_queue #(
    .N (DELIM_MAX)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_res_i    (res),
    .wr_n_i      (wr_n),
    .room_o      (room),
    .out_vld_o   (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (head)
  );

  assign out_byte        = head.out_byte;
  assign out_byte_valid  = head.byte_valid;
  assign out_field_end   = head.field_end;
  assign out_stream_end  = head.stream_end;
  assign out_quote_error = head.quote_error;

endmodule

// ===== src/dfs_resolver.sv =====
// Scan logic of the delimited field splitter: appends a byte to the held
// window, resolves it left to right and holds the scan state.
// Depends on dfs_pkg.
module dfs_resolver
  import dfs_pkg::*;
#(
  parameter int N = DELIM_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go_i,
  input  logic                       final_i,
  input  logic [7:0]                 byte_i,
  input  logic [2:0]                 dlen_cfg_i,
  input  logic [31:0]                delim_i,
  input  logic [7:0]                 quote_i,
  output result_t                    res_o [N],
  output logic [$clog2(N+1)-1:0]     res_n_o
);

  localparam int CW = $clog2(N+1);

  logic [7:0]    win_r   [N];
  logic [7:0]    win_nxt [N];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          iq_r, iq_nxt;

  logic [7:0]    dbyte [N];
  logic [7:0]    w     [N];
  logic [CW-1:0] c;
  logic [CW-1:0] dlen;
  logic [N-1:0]  eq    [N];
  logic [N-1:0]  full, pre;

  // Effective delimiter length: zero counts as one, and it never exceeds N.
  assign dlen = (dlen_cfg_i == 3'd0) ? CW'(1) :
                ((32'(dlen_cfg_i) > N) ? CW'(N) : CW'(dlen_cfg_i));

  always_comb begin : p_dbyte
    for (int g = 0; g < N; g++) begin
      dbyte[g] = (g < 4) ? delim_i[8*(g%4) +: 8] : 8'd0;
    end
  end

  // Window with the new byte appended.
  always_comb begin : p_append
    c = cnt_r;
    for (int i = 0; i < N; i++) w[i] = win_r[i];
    if (!final_i && (int'(cnt_r) < N)) begin
      for (int i = 0; i < N; i++) begin
        if (CW'(i) == cnt_r) w[i] = byte_i;
      end
      c = cnt_r + 1'b1;
    end
  end

  // Byte compares of every start position against every delimiter byte.
  always_comb begin : p_eq
    for (int s = 0; s < N; s++) begin
      for (int i = 0; i < N; i++) begin
        eq[s][i] = (s + i < N) ? (w[(s+i)%N] == dbyte[i]) : 1'b0;
      end
    end
  end

  // Full match and proper-prefix match at each start position.
  always_comb begin : p_match
    int rem;
    rem = 0;
    for (int s = 0; s < N; s++) begin
      rem     = int'(c) - s;
      full[s] = (rem >= int'(dlen));
      pre[s]  = (rem < int'(dlen));
      for (int i = 0; i < N; i++) begin
        if (i < int'(dlen)) full[s] = full[s] & eq[s][i];
        if (i < rem)        pre[s]  = pre[s] & eq[s][i];
      end
    end
  end

  // Left-to-right scan over the window, one position per step.
  always_comb begin : p_scan
    logic          iq;
    logic          held;
    logic [CW-1:0] skip;
    logic [CW-1:0] k;
    logic [CW-1:0] hs;
    result_t       r;
    iq   = iq_r;
    held = 1'b0;
    skip = '0;
    k    = '0;
    hs   = '0;
    r    = '0;
    for (int j = 0; j < N; j++) res_o[j] = '0;
    for (int s = 0; s < N; s++) begin
      r = '0;
      if ((CW'(s) < c) && (skip != '0)) begin
        skip = skip - 1'b1;
      end else if ((CW'(s) < c) && !held) begin
        if (iq) begin
          if (w[s] == quote_i) begin
            iq = 1'b0;
          end else begin
            r.out_byte   = w[s];
            r.byte_valid = 1'b1;
          end
        end else if (w[s] == quote_i) begin
          iq = 1'b1;
        end else if (full[s]) begin
          r.field_end = 1'b1;
          skip        = dlen - 1'b1;
        end else if (!final_i && pre[s]) begin
          held = 1'b1;
          hs   = CW'(s);
        end else begin
          r.out_byte   = w[s];
          r.byte_valid = 1'b1;
        end
      end
      if (r.byte_valid || r.field_end) begin
        for (int j = 0; j < N; j++) begin
          if (CW'(j) == k) res_o[j] = r;
        end
        k = k + 1'b1;
      end
    end

    if (final_i) begin
      r             = '0;
      r.field_end   = 1'b1;
      r.stream_end  = 1'b1;
      r.quote_error = iq;
      for (int j = 0; j < N; j++) begin
        if (CW'(j) == k) res_o[j] = r;
      end
      k = k + 1'b1;
    end
    res_n_o = k;

    // Next state: the held tail of the window moves to the front.
    for (int i = 0; i < N; i++) begin
      win_nxt[i] = 8'd0;
      if (!final_i && held && (int'(hs) + i < int'(c))) begin
        for (int j = 0; j < N; j++) begin
          if (j == int'(hs) + i) win_nxt[i] = w[j];
        end
      end
    end
    if (final_i) begin
      cnt_nxt = '0;
      iq_nxt  = 1'b0;
    end else begin
      cnt_nxt = held ? (c - hs) : '0;
      iq_nxt  = iq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      iq_r  <= 1'b0;
    end else if (go_i) begin
      cnt_r <= cnt_nxt;
      iq_r  <= iq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go_i) begin
      win_r <= win_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_held_short : assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) < N)
    else $error("held window reached its full size between items");

  a_quote_drains : assert property (@(posedge clk) disable iff (!rst_n)
    iq_r |-> (cnt_r == '0))
    else $error("bytes held while a quoted span is open");

  a_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (go_i && final_i) |=> ((cnt_r == '0) && !iq_r))
    else $error("scan state not cleared after end of stream");
`endif

endmodule

// ===== src/dfs_result_queue.sv =====
// Result queue of the delimited field splitter: takes up to N result items
// in a cycle and hands them out one per cycle while the receiver does not stall.
// Depends on dfs_pkg.
module dfs_result_queue
  import dfs_pkg::*;
#(
  parameter int N = DELIM_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  result_t                wr_res_i [N],
  input  logic [$clog2(N+1)-1:0] wr_n_i,
  output logic                   room_o,
  output logic                   out_vld_o,
  input  logic                   out_stall_i,
  output result_t                out_res_o
);

  localparam int CW  = $clog2(N+1);
  localparam int QD  = 2 * N;
  localparam int PW  = $clog2(QD);
  localparam int QCW = $clog2(QD+1);

  result_t        q_r [QD];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic [PW-1:0]  wslot [N];
  logic           rd;

  assign room_o    = (count_r <= QCW'(QD - N));
  assign out_vld_o = (count_r != '0);
  assign out_res_o = q_r[rd_ptr_r];
  assign rd        = out_vld_o && !out_stall_i;

  always_comb begin : p_ptr
    int sum;
    sum = 0;
    for (int k = 0; k < N; k++) begin
      sum = int'(wr_ptr_r) + k;
      if (sum >= QD) sum = sum - QD;
      wslot[k] = PW'(sum);
    end
    sum = int'(wr_ptr_r) + int'(wr_n_i);
    if (sum >= QD) sum = sum - QD;
    wr_ptr_nxt = PW'(sum);
    rd_ptr_nxt = rd_ptr_r;
    if (rd) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QD - 1) ? '0 : (rd_ptr_r + 1'b1);
    end
    count_nxt = count_r + QCW'(wr_n_i) - QCW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (CW'(k) < wr_n_i) q_r[wslot[k]] <= wr_res_i[k];
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (wr_n_i != '0) |-> room_o)
    else $error("results written without room in the queue");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QD))
    else $error("queue occupancy above its depth");

  a_ptr_agree : assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> ((count_r == '0) || (count_r == QCW'(QD))))
    else $error("queue pointers disagree with occupancy");
`endif

endmodule

// ===== verif/dfs_splitter_checker.sv =====
// Scoreboard for the delimited field splitter: follows the configuration port and
// both channels, works out each result item and compares it with what the block gives.
// Depends on dfs_pkg.
module dfs_splitter_checker
  import dfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_kind,
  input  logic [7:0]           in_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_byte,
  input  logic                 out_byte_valid,
  input  logic                 out_field_end,
  input  logic                 out_stream_end,
  input  logic                 out_quote_error,
  output int                   fail_count,
  output int                   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = DELIM_MAX_DEF;

  logic [2:0]  delim_len_q;
  logic [31:0] delim_bytes_q;
  logic [7:0]  quote_q;
  logic [7:0]  window [WIN];
  int          held;
  logic        in_span;
  result_t     tokens_due [$];
  int          failures = 0;

  function automatic int active_len();
    int n;
    n = int'(delim_len_q);
    if (n < 1) n = 1;
    if (n > WIN) n = WIN;
    return n;
  endfunction

  function automatic logic [7:0] delim_byte(int i);
    return (i < 4) ? delim_bytes_q[8*i +: 8] : 8'h00;
  endfunction

  function automatic void emit(logic [7:0] b, logic bv, logic fe, logic se, logic qe);
    result_t r;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.field_end   = fe;
    r.stream_end  = se;
    r.quote_error = qe;
    tokens_due.insert(tokens_due.size(), r);
  endfunction

  function automatic void drop_head(int k);
    if (k > held) k = held;
    for (int i = 0; i + k < held; i++) window[i] = window[i + k];
    for (int i = held - k; i < held; i++) window[i] = 8'h00;
    held -= k;
  endfunction

  function automatic bit head_is_delim(int n);
    for (int i = 0; i < n; i++)
      if (window[i] != delim_byte(i)) return 1'b0;
    return 1'b1;
  endfunction

  // Works through the held bytes from the oldest one, as a left to right scan
  // would. Without a flush, a window that may still grow into a delimiter stays.
  function automatic void resolve_window(bit flush);
    int         dlen;
    logic [7:0] b;
    dlen = active_len();
    while (held > 0) begin
      b = window[0];
      if (in_span) begin
        drop_head(1);
        if (b == quote_q) in_span = 1'b0;
        else emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
        continue;
      end
      if (b == quote_q) begin
        in_span = 1'b1;
        drop_head(1);
        continue;
      end
      if (held >= dlen && head_is_delim(dlen)) begin
        emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        drop_head(dlen);
        continue;
      end
      if (!flush && held < dlen && head_is_delim(held)) break;
      emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
      drop_head(1);
    end
  endfunction

  function automatic void split_item(logic closes_stream, logic [7:0] b);
    if (!closes_stream) begin
      if (held < WIN) begin
        window[held] = b;
        held++;
      end
      resolve_window(1'b0);
    end else begin
      resolve_window(1'b1);
      emit(8'h00, 1'b0, 1'b1, 1'b1, in_span);
      foreach (window[i]) window[i] = 8'h00;
      held    = 0;
      in_span = 1'b0;
    end
  endfunction

  function automatic void log_failure(string msg);
    if (failures < 10) $display("[%0t] %s", $realtime, msg);
    failures++;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      delim_len_q   = DELIM_LEN_RST;
      delim_bytes_q = DELIM_BYTES_RST;
      quote_q       = QUOTE_RST;
      foreach (window[i]) window[i] = 8'h00;
      held    = 0;
      in_span = 1'b0;
      tokens_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELIM_LEN:   delim_len_q   = cfg_data[2:0];
          CFG_DELIM_BYTES: delim_bytes_q = cfg_data;
          CFG_QUOTE:       quote_q       = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) split_item(in_kind, in_byte);
      if (out_valid && !out_stall) begin
        seen = {out_byte, out_byte_valid, out_field_end, out_stream_end, out_quote_error};
        if (tokens_due.size() == 0) begin
          log_failure($sformatf("unexpected result: byte %02h bv %0b fe %0b se %0b qe %0b",
                                seen.out_byte, seen.byte_valid, seen.field_end,
                                seen.stream_end, seen.quote_error));
        end else begin
          want = tokens_due.pop_front();
          if (seen.out_byte !== want.out_byte || seen.byte_valid !== want.byte_valid ||
              seen.field_end !== want.field_end || seen.stream_end !== want.stream_end ||
              seen.quote_error !== want.quote_error) begin
            log_failure($sformatf({"mismatch: expected byte %02h bv %0b fe %0b se %0b qe %0b,",
                                   " got byte %02h bv %0b fe %0b se %0b qe %0b"},
                                  want.out_byte, want.byte_valid, want.field_end,
                                  want.stream_end, want.quote_error,
                                  seen.out_byte, seen.byte_valid, seen.field_end,
                                  seen.stream_end, seen.quote_error));
          end
        end
      end
    end
    results_owed <= tokens_due.size();
    fail_count   <= failures;
  end

endmodule

// ===== verif/delimited_field_splitter_core_tb.sv =====
// Testbench top for delimited_field_splitter_core: clock, reset, stimulus and verdict.
// Depends on dfs_pkg, the block itself and dfs_splitter_checker, which does the checking.
module delimited_field_splitter_core_tb
  import dfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Meaning of in_kind: a data byte, or the end of a stream.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT = 300000;
  // Smallest number of random items sent in each of the six configuration sections.
  localparam int SECTION_ITEMS = 62;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_kind;
  logic [7:0]           in_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_byte;
  logic                 out_byte_valid;
  logic                 out_field_end;
  logic                 out_stream_end;
  logic                 out_quote_error;

  int fail_count;
  int results_owed;
  int cycle_count = 0;
  int items_sent  = 0;

  // Chance, in percent, that the sender leaves a cycle empty and that the
  // receiver stalls in a cycle.
  int tx_idle_pct = 19;
  int rx_idle_pct = 81;

  // The settings in force, kept only to shape the stimulus.
  int          eff_len;
  logic [31:0] delim_word;
  logic [7:0]  quote_val;

  delimited_field_splitter_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_field_end   (out_field_end),
    .out_stream_end  (out_stream_end),
    .out_quote_error (out_quote_error)
  );

  dfs_splitter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_field_end   (out_field_end),
    .out_stream_end  (out_stream_end),
    .out_quote_error (out_quote_error),
    .fail_count      (fail_count),
    .results_owed    (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides afresh at every falling edge whether to stall.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL delimited_field_splitter_core");
      $finish;
    end
  end

  // Offers one item, after random empty cycles, and holds it until the block
  // takes it. The payload is scrambled while valid is low, never while held.
  task automatic send_item(logic kind, logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_kind  <= 1'($urandom_range(0, 1));
      in_byte  <= 8'($urandom_range(0, 255));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering items and waits until every predicted result has come
  // out. An item that gives no result may still be inside the block then, so
  // the task waits on until such an item has passed through the scan.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Writes all three registers while the block is idle. Bytes still held
  // from an unfinished stream are then resolved under the new settings.
  task automatic apply_settings(logic [31:0] len_word, logic [31:0] delim,
                                logic [31:0] quote_word);
    drain();
    write_reg(CFG_DELIM_LEN, len_word);
    write_reg(CFG_DELIM_BYTES, delim);
    write_reg(CFG_QUOTE, quote_word);
    @(negedge clk);
    cfg_we <= 1'b0;
    eff_len = int'(len_word[2:0]);
    if (eff_len < 1) eff_len = 1;
    if (eff_len > DELIM_MAX_DEF) eff_len = DELIM_MAX_DEF;
    delim_word = delim;
    quote_val  = quote_word[7:0];
  endtask

  // Random bits above the ones that a register keeps.
  function automatic logic [31:0] with_noise(logic [31:0] low, int bits);
    return ($urandom() << bits) | low;
  endfunction

  // Any byte but the quote, so that plain and quoted content stays well formed.
  function automatic logic [7:0] content_byte(bit lean_to_delim);
    logic [7:0] b;
    if (lean_to_delim && $urandom_range(0, 2) == 0)
      b = delim_word[8*$urandom_range(0, eff_len - 1) +: 8];
    else
      b = 8'($urandom_range(0, 255));
    if (b == quote_val) b ^= 8'h01;
    return b;
  endfunction

  task automatic send_delim();
    for (int i = 0; i < eff_len; i++) send_item(KIND_DATA, delim_word[8*i +: 8]);
  endtask

  task automatic send_plain_field();
    int n;
    int k;
    n = $urandom_range(0, 5);
    repeat (n) begin
      if (eff_len > 1 && $urandom_range(0, 4) == 0) begin
        // A proper prefix of the delimiter, so the next byte forces the match
        // to start again and the held bytes to come out as content.
        k = $urandom_range(1, eff_len - 1);
        for (int i = 0; i < k; i++) send_item(KIND_DATA, delim_word[8*i +: 8]);
      end else begin
        send_item(KIND_DATA, content_byte(1'b0));
      end
    end
  endtask

  // Quoted content leans towards delimiter bytes, which must pass through.
  task automatic send_quoted_field();
    int n;
    n = $urandom_range(0, 5);
    send_item(KIND_DATA, quote_val);
    repeat (n) send_item(KIND_DATA, content_byte(1'b1));
    send_item(KIND_DATA, quote_val);
  endtask

  // A well formed stream: fields split by whole delimiters, closed by an end item.
  task automatic send_record();
    int fields;
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) send_delim();
      if ($urandom_range(0, 3) == 0) send_quoted_field();
      else send_plain_field();
    end
    send_item(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // Noise: loose quotes, stray delimiter bytes and early end items.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       send_item(KIND_END, 8'($urandom_range(0, 255)));
        1, 2:    send_item(KIND_DATA, quote_val);
        3, 4:    send_item(KIND_DATA, delim_word[8*$urandom_range(0, 3) +: 8]);
        default: send_item(KIND_DATA, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [31:0] d;
    int          target;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_DELIM_LEN;
    cfg_data   = 32'h0;
    in_valid   = 1'b0;
    in_kind    = KIND_DATA;
    in_byte    = 8'h00;
    eff_len    = int'(DELIM_LEN_RST);
    delim_word = DELIM_BYTES_RST;
    quote_val  = QUOTE_RST;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: comma and double quote.
    // An empty stream gives a single final field end.
    send_item(KIND_END, 8'hFF);
    // Two fields, the second holding the extreme byte values.
    send_item(KIND_DATA, "a");
    send_item(KIND_DATA, ",");
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_END, 8'h00);
    // A comma inside quotes is content; both quotes are dropped.
    send_item(KIND_DATA, "\"");
    send_item(KIND_DATA, ",");
    send_item(KIND_DATA, "b");
    send_item(KIND_DATA, "\"");
    send_item(KIND_DATA, ",");
    send_item(KIND_END, 8'h00);
    // A quote left open flags the final field end.
    send_item(KIND_DATA, "\"");
    send_item(KIND_DATA, "c");
    send_item(KIND_END, 8'h00);

    // Carriage return and line feed as a two byte delimiter, single quote.
    // The doubled carriage return makes the match restart, and the lone one
    // held at the end is flushed as content.
    apply_settings(32'd2, 32'h0000_0A0D, 32'h27);
    send_item(KIND_DATA, "x");
    send_item(KIND_DATA, 8'h0D);
    send_item(KIND_DATA, 8'h0D);
    send_item(KIND_DATA, 8'h0A);
    send_item(KIND_DATA, 8'h0D);
    send_item(KIND_END, 8'h00);

    // A delimiter that begins with the quote byte: the quote test wins.
    apply_settings(32'd2, 32'h0000_2C22, 32'h22);
    send_item(KIND_DATA, "\"");
    send_item(KIND_DATA, ",");
    send_item(KIND_DATA, "\"");
    send_item(KIND_END, 8'h00);

    // Random part: six sections, each under its own settings, with the
    // idling pattern moving from a slow receiver to a slow sender to none.
    for (int s = 0; s < 6; s++) begin
      d = $urandom();
      case (s)
        0: apply_settings(with_noise(32'd1, 3), with_noise(32'h2C, 8), with_noise(32'h22, 8));
        1: apply_settings(32'd4, 32'hFFFF_FFFF, 32'h00);
        // A length of zero behaves as one.
        2: apply_settings(with_noise(32'd0, 3), 32'h0, with_noise(32'hFF, 8));
        // A length above the window size behaves as four.
        3: apply_settings(32'd7, d, with_noise($urandom_range(0, 255), 8));
        4: apply_settings(32'd2, with_noise(32'h0A0D, 16), 32'h22);
        // The quote byte sits inside the delimiter, in second place.
        default: apply_settings(32'd3, d, {24'h0, d[15:8]});
      endcase
      case (s / 2)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      target = items_sent + SECTION_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 8) send_record();
        else send_noise();
      end
    end

    drain();
    if (fail_count == 0 && results_owed == 0)
      $display("PASS delimited_field_splitter_core");
    else
      $display("FAIL delimited_field_splitter_core");
    $finish;
  end

endmodule

// ===== delimited_field_splitter_core.f =====
src/dfs_pkg.sv
src/dfs_resolver.sv
src/dfs_result_queue.sv
src/delimited_field_splitter_core.sv
verif/dfs_splitter_checker.sv
verif/delimited_field_splitter_core_tb.sv
